// ----- hw/rtl/ipfc_pkg.sv -----
`default_nettype none
package ipfc_pkg;

	localparam int ADDR_W   = 32;
	localparam int LEN_W    = 6;
	localparam int TIME_W   = 64;
	localparam int COUNT_W  = 32;
	localparam int MARK_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 64;

	// Request codes
	localparam logic [1:0] REQ_PACKET     = 2'd0;
	localparam logic [1:0] REQ_LOAD_BLOCK = 2'd1;
	localparam logic [1:0] REQ_LOAD_ALLOW = 2'd2;

	// Matched side codes
	localparam logic [1:0] SIDE_NONE = 2'd0;
	localparam logic [1:0] SIDE_DST  = 2'd1;
	localparam logic [1:0] SIDE_SRC  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HOT_COUNT_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOT_AGE_NS          = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MARK_WORD           = 2'd2;

	localparam logic [COUNT_W-1:0] RST_HOT_COUNT_THRESHOLD = 32'd20;
	localparam logic [TIME_W-1:0]  RST_HOT_AGE_NS          = 64'd10000000000;
	localparam logic [MARK_W-1:0]  RST_MARK_WORD           = 32'h0000_0088;

	localparam logic [ADDR_W-1:0] PRIV_A_MASK = 32'hFF00_0000;
	localparam logic [ADDR_W-1:0] PRIV_A_NET  = 32'h0A00_0000;
	localparam logic [ADDR_W-1:0] PRIV_B_MASK = 32'hFFF0_0000;
	localparam logic [ADDR_W-1:0] PRIV_B_NET  = 32'hAC10_0000;
	localparam logic [ADDR_W-1:0] PRIV_C_MASK = 32'hFFFF_0000;
	localparam logic [ADDR_W-1:0] PRIV_C_NET  = 32'hC0A8_0000;
	localparam logic [LEN_W-1:0]  MAX_LEN     = 6'd32;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;

	typedef enum logic {PFX_LOOKUP, PFX_INSERT} pfx_op_t;
	typedef enum logic {LRU_FIND, LRU_INSERT} lru_op_t;

	typedef struct packed {
		logic              go;
		pfx_op_t           op;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
	} pfx_req_t;

	typedef struct packed {
		logic done;
		logic flag;   // match for lookup, full for insert
	} pfx_rsp_t;

	typedef struct packed {
		logic              go;
		lru_op_t           op;
		logic [ADDR_W-1:0] addr;
	} lru_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} lru_rsp_t;

	typedef enum logic [1:0] {P_IDLE, P_RD, P_EV, P_DONE} pfx_state_t;

	typedef enum logic [3:0] {
		L_IDLE, L_FRD, L_FEV, L_RRD, L_REV, L_SRD, L_SEV, L_MRD, L_MEV, L_DONE
	} lru_state_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_LOAD_W, S_BLK, S_BLK_W, S_HOT, S_HOT_W, S_PRE, S_PRE_W,
		S_AUX, S_PROMO, S_PROMO_W, S_ALW, S_ALW_W, S_SEED, S_SEED_W, S_HIT,
		S_MISS, S_OUT
	} top_state_t;

	function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		if (len >= MAX_LEN) m = '1;
		else m = ~({ADDR_W{1'b1}} >> len);
		return m;
	endfunction

	function automatic logic is_private(input logic [ADDR_W-1:0] a);
		return ((a & PRIV_A_MASK) == PRIV_A_NET) ||
			((a & PRIV_B_MASK) == PRIV_B_NET) ||
			((a & PRIV_C_MASK) == PRIV_C_NET);
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ipfc_pfx_table.sv -----
`default_nettype none
module ipfc_pfx_table #(
	parameter int N = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ipfc_pkg::pfx_req_t req,
	output ipfc_pkg::pfx_rsp_t     rsp
);
	import ipfc_pkg::*;

	localparam int IW = (N > 1) ? $clog2(N) : 1;
	localparam int CW = $clog2(N + 1);
	localparam logic [CW-1:0] DEPTH = CW'(N);

	logic [LEN_W+ADDR_W-1:0] mem [N];
	logic [LEN_W+ADDR_W-1:0] rdata_q;

	pfx_state_t state_q, state_d;
	logic [CW-1:0]     cnt_q, i_q;
	pfx_op_t           op_q;
	logic [ADDR_W-1:0] a_q;
	logic [LEN_W-1:0]  len_q;
	logic              flag_q;

	logic [LEN_W-1:0]  in_len, r_len;
	logic [ADDR_W-1:0] r_base;
	logic              ev_hit, at_end, we;

	assign in_len = (req.len > MAX_LEN) ? MAX_LEN : req.len;
	assign r_len  = rdata_q[LEN_W+ADDR_W-1:ADDR_W];
	assign r_base = rdata_q[ADDR_W-1:0];
	assign at_end = (i_q == cnt_q);
	// entry compare: prefix match on lookup, exact duplicate on insert
	assign ev_hit = (op_q == PFX_LOOKUP) ? ((a_q & len_mask(r_len)) == r_base)
		: ((r_len == len_q) && (r_base == a_q));
	assign we = (state_q == P_RD) && at_end && (op_q == PFX_INSERT) && (cnt_q < DEPTH);

	// storage
	always_ff @(posedge clk) begin
		if (we) mem[cnt_q[IW-1:0]] <= {len_q, a_q};
		rdata_q <= mem[i_q[IW-1:0]];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			P_IDLE: if (req.go) state_d = P_RD;
			P_RD:   state_d = at_end ? P_DONE : P_EV;
			P_EV:   state_d = ev_hit ? P_DONE : P_RD;
			P_DONE: state_d = P_IDLE;
			default: state_d = P_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rsp.done = (state_q == P_DONE);
		rsp.flag = flag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (we) cnt_q <= cnt_q + CW'(1);
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			P_IDLE: begin
				op_q   <= req.op;
				i_q    <= '0;
				flag_q <= 1'b0;
				len_q  <= in_len;
				a_q    <= (req.op == PFX_INSERT) ? (req.addr & len_mask(in_len)) : req.addr;
			end
			P_RD: begin
				if (at_end) flag_q <= (op_q == PFX_INSERT) && (cnt_q == DEPTH);
			end
			P_EV: begin
				if (ev_hit) flag_q <= (op_q == PFX_LOOKUP);
				else i_q <= i_q + CW'(1);
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/ipfc_lru_cache.sv -----
`default_nettype none
module ipfc_lru_cache #(
	parameter int N = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ipfc_pkg::lru_req_t req,
	output ipfc_pkg::lru_rsp_t      rsp,
	output logic [((N > 1) ? $clog2(N) : 1)-1:0] idx
);
	import ipfc_pkg::*;

	localparam int IW = (N > 1) ? $clog2(N) : 1;
	localparam int CW = $clog2(N + 1);
	localparam logic [CW-1:0] DEPTH = CW'(N);

	logic [ADDR_W-1:0] addr_mem [N];
	logic [IW-1:0]     rank_mem [N];
	logic [ADDR_W-1:0] addr_rdata_q;
	logic [IW-1:0]     rank_rdata_q;

	lru_state_t state_q, state_d;
	logic [CW-1:0]     cnt_q, i_q, lim_q;
	logic [IW-1:0]     idx_q, r_q;
	logic [ADDR_W-1:0] a_q;
	logic              hit_q, inc_q;

	logic [IW-1:0]     rd_idx, rank_new;
	logic              addr_we, free_ins, sweep_end, max_end;
	logic [IW-1:0]     addr_widx;
	logic [ADDR_W-1:0] addr_wdata;

	assign free_ins  = (state_q == L_IDLE) && req.go && (req.op == LRU_INSERT) && (cnt_q < DEPTH);
	assign sweep_end = (i_q == lim_q);
	assign max_end   = (i_q == DEPTH);
	assign rd_idx    = (state_q == L_RRD) ? idx_q : i_q[IW-1:0];
	assign addr_we   = free_ins || ((state_q == L_MRD) && max_end);
	assign addr_widx = (state_q == L_IDLE) ? cnt_q[IW-1:0] : idx_q;
	assign addr_wdata = (state_q == L_IDLE) ? req.addr : a_q;

	// rank update: touched/new entry goes to 0, younger ones (or all on fill) age by one
	assign rank_new = (i_q[IW-1:0] == idx_q) ? '0
		: (inc_q || (rank_rdata_q < r_q)) ? rank_rdata_q + IW'(1) : rank_rdata_q;

	// storage
	always_ff @(posedge clk) begin
		if (addr_we) addr_mem[addr_widx] <= addr_wdata;
		if (state_q == L_SEV) rank_mem[i_q[IW-1:0]] <= rank_new;
		addr_rdata_q <= addr_mem[rd_idx];
		rank_rdata_q <= rank_mem[rd_idx];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			L_IDLE: begin
				if (req.go) begin
					if (req.op == LRU_FIND) state_d = L_FRD;
					else if (cnt_q < DEPTH) state_d = L_SRD;
					else state_d = L_MRD;
				end
			end
			L_FRD: state_d = (i_q == cnt_q) ? L_DONE : L_FEV;
			L_FEV: state_d = (addr_rdata_q == a_q) ? L_RRD : L_FRD;
			L_RRD: state_d = L_REV;
			L_REV: state_d = L_SRD;
			L_SRD: state_d = sweep_end ? L_DONE : L_SEV;
			L_SEV: state_d = L_SRD;
			L_MRD: state_d = max_end ? L_SRD : L_MEV;
			L_MEV: state_d = L_MRD;
			L_DONE: state_d = L_IDLE;
			default: state_d = L_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rsp.done = (state_q == L_DONE);
		rsp.hit  = hit_q;
		idx      = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (free_ins) cnt_q <= cnt_q + CW'(1);
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			L_IDLE: begin
				a_q   <= req.addr;
				i_q   <= '0;
				hit_q <= 1'b0;
				inc_q <= 1'b1;
				r_q   <= '0;
				lim_q <= cnt_q + CW'(1);
				idx_q <= (cnt_q < DEPTH) ? cnt_q[IW-1:0] : '0;
			end
			L_FEV: begin
				if (addr_rdata_q == a_q) begin
					hit_q <= 1'b1;
					idx_q <= i_q[IW-1:0];
				end else begin
					i_q <= i_q + CW'(1);
				end
			end
			L_REV: begin
				r_q   <= rank_rdata_q;
				inc_q <= 1'b0;
				lim_q <= cnt_q;
				i_q   <= '0;
			end
			L_SEV: i_q <= i_q + CW'(1);
			L_MRD: begin
				if (max_end) begin
					inc_q <= 1'b0;
					lim_q <= cnt_q;
					i_q   <= '0;
				end
			end
			L_MEV: begin
				// first entry holding the oldest rank is the victim
				if ((i_q == '0) || (rank_rdata_q > r_q)) begin
					r_q   <= rank_rdata_q;
					idx_q <= i_q[IW-1:0];
				end
				i_q <= i_q + CW'(1);
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/ip_fastpath_classifier_unit.sv -----
`default_nettype none
// IPv4 fast-path classifier. Each input transfer is either a block-list or
// allow-list prefix load, or a packet (addresses plus timestamp); each gives
// exactly one result transfer. Tables are searched one entry at a time by
// small sequencers, and a packet checks destination then source through
// block list, hot cache, pre-cache and allow list, with LRU rank sweeps on
// hits and inserts. The input stalls while an item is in progress; a
// finished result sits in the output register and does not hold up the next
// input. No clearing pass after reset is needed.
module ip_fastpath_classifier_unit #(
	parameter int BLOCK_ENTRIES = 256,
	parameter int ALLOW_ENTRIES = 256,
	parameter int HOT_ENTRIES   = 256,
	parameter int PRE_ENTRIES   = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [ipfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ipfc_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic        ipv4_ok,
	input  wire logic [31:0] src_addr,
	input  wire logic [31:0] dst_addr,
	input  wire logic [63:0] now_ns,
	input  wire logic [31:0] prefix_addr,
	input  wire logic [5:0]  prefix_len,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             accelerate,
	output logic [31:0]      mark_out,
	output logic [1:0]       matched_side,
	output logic             load_status
);
	import ipfc_pkg::*;

	localparam int PIW = (PRE_ENTRIES > 1) ? $clog2(PRE_ENTRIES) : 1;
	localparam int AUX_W = COUNT_W + TIME_W;

	// configuration
	logic [COUNT_W-1:0] thr_q;
	logic [TIME_W-1:0]  age_q;
	logic [MARK_W-1:0]  mark_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= RST_HOT_COUNT_THRESHOLD;
			age_q  <= RST_HOT_AGE_NS;
			mark_q <= RST_MARK_WORD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HOT_COUNT_THRESHOLD: thr_q <= cfg_data[COUNT_W-1:0];
				CFG_HOT_AGE_NS:          age_q <= cfg_data;
				CFG_MARK_WORD:           mark_q <= cfg_data[MARK_W-1:0];
				default: ;
			endcase
		end
	end

	top_state_t state_q, state_d;
	logic [1:0]        req_q;
	logic [ADDR_W-1:0] src_q, dst_q, paddr_q;
	logic [TIME_W-1:0] now_q;
	logic [LEN_W-1:0]  plen_q;
	logic              cur_src_q, acc_q, status_q;
	logic [1:0]        side_q;
	logic              out_valid_q, out_acc_q, out_status_q;
	logic [MARK_W-1:0] out_mark_q;
	logic [1:0]        out_side_q;

	logic [ADDR_W-1:0] cur_addr;
	logic              in_xfer, bypass, out_load;

	pfx_req_t blk_req, alw_req;
	pfx_rsp_t blk_rsp, alw_rsp;
	lru_req_t hot_req, pre_req;
	lru_rsp_t hot_rsp, pre_rsp;
	logic [PIW-1:0] pre_idx;

	assign cur_addr = cur_src_q ? src_q : dst_q;
	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign bypass   = (req_type != REQ_PACKET) || !ipv4_ok
		|| (is_private(src_addr) && is_private(dst_addr));
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// pre-cache count and first sighting
	logic [AUX_W-1:0]   aux_mem [PRE_ENTRIES];
	logic [AUX_W-1:0]   aux_rdata_q;
	logic [COUNT_W-1:0] aux_cnt, cnt_next;
	logic [TIME_W-1:0]  aux_first;
	logic               promote, aux_we;
	logic [AUX_W-1:0]   aux_wdata;

	assign aux_cnt   = aux_rdata_q[AUX_W-1:TIME_W];
	assign aux_first = aux_rdata_q[TIME_W-1:0];
	assign cnt_next  = (aux_cnt == COUNT_MAX) ? aux_cnt : aux_cnt + COUNT_W'(1);
	assign promote   = (cnt_next >= thr_q) && ((now_q - aux_first) > age_q);
	assign aux_we    = (state_q == S_AUX) || ((state_q == S_SEED_W) && pre_rsp.done);
	assign aux_wdata = (state_q == S_AUX) ? {cnt_next, aux_first}
		: {COUNT_W'(1), now_q};

	always_ff @(posedge clk) begin
		if (aux_we) aux_mem[pre_idx] <= aux_wdata;
		aux_rdata_q <= aux_mem[pre_idx];
	end

	// table units
	ipfc_pfx_table #(.N(BLOCK_ENTRIES)) u_block (
		.clk(clk), .arst_n(arst_n), .req(blk_req), .rsp(blk_rsp));
	ipfc_pfx_table #(.N(ALLOW_ENTRIES)) u_allow (
		.clk(clk), .arst_n(arst_n), .req(alw_req), .rsp(alw_rsp));
	ipfc_lru_cache #(.N(HOT_ENTRIES)) u_hot (
		.clk(clk), .arst_n(arst_n), .req(hot_req), .rsp(hot_rsp), .idx());
	ipfc_lru_cache #(.N(PRE_ENTRIES)) u_pre (
		.clk(clk), .arst_n(arst_n), .req(pre_req), .rsp(pre_rsp), .idx(pre_idx));

	// unit requests; a private address skips the block-list scan
	always_comb begin
		blk_req.go   = ((state_q == S_LOAD) && (req_q == REQ_LOAD_BLOCK))
			|| ((state_q == S_BLK) && !is_private(cur_addr));
		blk_req.op   = (state_q == S_LOAD) ? PFX_INSERT : PFX_LOOKUP;
		blk_req.addr = (state_q == S_LOAD) ? paddr_q : cur_addr;
		blk_req.len  = plen_q;
		alw_req.go   = ((state_q == S_LOAD) && (req_q == REQ_LOAD_ALLOW)) || (state_q == S_ALW);
		alw_req.op   = (state_q == S_LOAD) ? PFX_INSERT : PFX_LOOKUP;
		alw_req.addr = (state_q == S_LOAD) ? paddr_q : cur_addr;
		alw_req.len  = plen_q;
		hot_req.go   = (state_q == S_HOT) || (state_q == S_PROMO);
		hot_req.op   = (state_q == S_PROMO) ? LRU_INSERT : LRU_FIND;
		hot_req.addr = cur_addr;
		pre_req.go   = (state_q == S_PRE) || (state_q == S_SEED);
		pre_req.op   = (state_q == S_SEED) ? LRU_INSERT : LRU_FIND;
		pre_req.addr = cur_addr;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					if ((req_type == REQ_LOAD_BLOCK) || (req_type == REQ_LOAD_ALLOW)) state_d = S_LOAD;
					else if (bypass) state_d = S_OUT;
					else state_d = S_BLK;
				end
			end
			S_LOAD:   state_d = S_LOAD_W;
			S_LOAD_W: if (blk_rsp.done || alw_rsp.done) state_d = S_OUT;
			S_BLK:    state_d = is_private(cur_addr) ? S_MISS : S_BLK_W;
			S_BLK_W:  if (blk_rsp.done) state_d = blk_rsp.flag ? S_MISS : S_HOT;
			S_HOT:    state_d = S_HOT_W;
			S_HOT_W:  if (hot_rsp.done) state_d = hot_rsp.hit ? S_HIT : S_PRE;
			S_PRE:    state_d = S_PRE_W;
			S_PRE_W:  if (pre_rsp.done) state_d = pre_rsp.hit ? S_AUX : S_ALW;
			S_AUX:    state_d = promote ? S_PROMO : S_HIT;
			S_PROMO:  state_d = S_PROMO_W;
			S_PROMO_W: if (hot_rsp.done) state_d = S_HIT;
			S_ALW:    state_d = S_ALW_W;
			S_ALW_W:  if (alw_rsp.done) state_d = alw_rsp.flag ? S_SEED : S_MISS;
			S_SEED:   state_d = S_SEED_W;
			S_SEED_W: if (pre_rsp.done) state_d = S_HIT;
			S_HIT:    state_d = S_OUT;
			S_MISS:   state_d = cur_src_q ? S_OUT : S_BLK;
			S_OUT:    if (out_load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// item registers and result
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q     <= req_type;
			src_q     <= src_addr;
			dst_q     <= dst_addr;
			now_q     <= now_ns;
			paddr_q   <= prefix_addr;
			plen_q    <= prefix_len;
			cur_src_q <= 1'b0;
			acc_q     <= 1'b0;
			side_q    <= SIDE_NONE;
			status_q  <= 1'b0;
		end
		if ((state_q == S_LOAD_W) && (blk_rsp.done || alw_rsp.done))
			status_q <= blk_rsp.done ? blk_rsp.flag : alw_rsp.flag;
		if (state_q == S_HIT) begin
			acc_q  <= 1'b1;
			side_q <= cur_src_q ? SIDE_SRC : SIDE_DST;
		end
		if (state_q == S_MISS) cur_src_q <= 1'b1;
		if (out_load) begin
			out_acc_q    <= acc_q;
			out_mark_q   <= acc_q ? mark_q : '0;
			out_side_q   <= side_q;
			out_status_q <= status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign accelerate   = out_acc_q;
	assign mark_out     = out_mark_q;
	assign matched_side = out_side_q;
	assign load_status  = out_status_q;

endmodule
`default_nettype wire

// ----- hw/rtl/ipfc_checker.sv -----
`default_nettype none
module ipfc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        accelerate,
	input wire logic [31:0] mark_out,
	input wire logic [1:0]  matched_side,
	input wire logic        load_status
);
	// an accepted item keeps the input busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after transfer");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(mark_out)
		&& $stable(accelerate) && $stable(matched_side) && $stable(load_status)))
		else $error("stalled result changed");

	// side is reported exactly for accelerated packets
	a_side_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accelerate == (matched_side != 2'd0)))
		else $error("matched_side disagrees with accelerate");

	// no mark without acceleration
	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accelerate) |-> (mark_out == 32'd0))
		else $error("mark on non-accelerated result");

	// a full-list report never comes with acceleration
	a_status_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && load_status) |-> !accelerate)
		else $error("load status on accelerated result");
endmodule

bind ip_fastpath_classifier_unit ipfc_checker u_ipfc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .accelerate(accelerate),
	.mark_out(mark_out), .matched_side(matched_side), .load_status(load_status));
`default_nettype wire

// ----- test/ip_fastpath_classifier_unit_tb.sv -----
`timescale 1ns / 1ps
module ip_fastpath_classifier_unit_tb;
	import ipfc_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int LIST_N = 256;
	localparam int CACHE_N = 256;
	localparam int POOL_N = 12;

	typedef struct packed {
		bit        acc;
		bit [31:0] mark;
		bit [1:0]  side;
		bit        full;
	} verdict_t;

	typedef struct {
		bit        v;
		bit [31:0] base;
		bit [5:0]  len;
	} prefix_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid, in_stall;
	logic [1:0] req_type;
	logic ipv4_ok;
	logic [31:0] src_addr, dst_addr, prefix_addr;
	logic [63:0] now_ns;
	logic [5:0] prefix_len;
	logic out_valid, out_stall;
	logic accelerate, load_status;
	logic [31:0] mark_out;
	logic [1:0] matched_side;

	ip_fastpath_classifier_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .ipv4_ok(ipv4_ok), .src_addr(src_addr), .dst_addr(dst_addr),
		.now_ns(now_ns), .prefix_addr(prefix_addr), .prefix_len(prefix_len),
		.out_valid(out_valid), .out_stall(out_stall),
		.accelerate(accelerate), .mark_out(mark_out), .matched_side(matched_side),
		.load_status(load_status)
	);

	// predictor state
	bit [31:0] thr_cfg;
	bit [63:0] age_cfg;
	bit [31:0] mark_cfg;
	prefix_t blk_list [LIST_N];
	prefix_t alw_list [LIST_N];
	bit hot_v [CACHE_N];
	bit [31:0] hot_a [CACHE_N];
	int unsigned hot_rank [CACHE_N];
	bit pre_v [CACHE_N];
	bit [31:0] pre_a [CACHE_N];
	int unsigned pre_rank [CACHE_N];
	bit [63:0] pre_first [CACHE_N];
	bit [31:0] pre_cnt [CACHE_N];

	verdict_t verdict_q [$];
	int errors, items_sent, results_seen, promotions, drops;
	int hold_long;
	bit rush;
	bit [63:0] clock_ns;
	bit [31:0] pool [POOL_N];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("ip_fastpath_classifier_unit_tb NOT OK");
		$finish;
	end

	function automatic bit [31:0] prefix_mask(bit [5:0] l);
		if (l == 0) return 32'h0;
		return ~(32'hFFFF_FFFF >> l);
	endfunction

	function automatic bit private_net(bit [31:0] a);
		return a[31:24] == 8'h0A || a[31:20] == 12'hAC1 || a[31:16] == 16'hC0A8;
	endfunction

	function automatic bit list_match(ref prefix_t t [LIST_N], input bit [31:0] a);
		for (int i = 0; i < LIST_N; i++)
			if (t[i].v && (a & prefix_mask(t[i].len)) == t[i].base) return 1'b1;
		return 1'b0;
	endfunction

	// returns 1 when the list is full and the prefix is dropped
	function automatic bit list_add(ref prefix_t t [LIST_N], input bit [31:0] a,
			input bit [5:0] l);
		bit [31:0] b;
		if (l > 32) l = 32;
		b = a & prefix_mask(l);
		for (int i = 0; i < LIST_N; i++)
			if (t[i].v && t[i].len == l && t[i].base == b) return 1'b0;
		for (int i = 0; i < LIST_N; i++)
			if (!t[i].v) begin
				t[i].v = 1'b1;
				t[i].base = b;
				t[i].len = l;
				return 1'b0;
			end
		return 1'b1;
	endfunction

	function automatic int cache_find(ref bit v [CACHE_N], ref bit [31:0] ad [CACHE_N],
			input bit [31:0] a);
		for (int i = 0; i < CACHE_N; i++)
			if (v[i] && ad[i] == a) return i;
		return -1;
	endfunction

	function automatic void cache_touch(ref bit v [CACHE_N], ref int unsigned rk [CACHE_N],
			input int idx);
		int unsigned r;
		r = rk[idx];
		for (int i = 0; i < CACHE_N; i++)
			if (i != idx && v[i] && rk[i] < r) rk[i]++;
		rk[idx] = 0;
	endfunction

	// free slot first, else the least recently used one
	function automatic int cache_place(ref bit v [CACHE_N], ref bit [31:0] ad [CACHE_N],
			ref int unsigned rk [CACHE_N], input bit [31:0] a);
		int slot;
		slot = -1;
		for (int i = 0; i < CACHE_N; i++)
			if (!v[i]) begin
				slot = i;
				break;
			end
		if (slot >= 0) begin
			for (int i = 0; i < CACHE_N; i++)
				if (v[i]) rk[i]++;
			rk[slot] = 0;
		end else begin
			slot = 0;
			for (int i = 1; i < CACHE_N; i++)
				if (rk[i] > rk[slot]) slot = i;
			cache_touch(v, rk, slot);
		end
		v[slot] = 1'b1;
		ad[slot] = a;
		return slot;
	endfunction

	function automatic bit addr_passes(bit [31:0] a, bit [63:0] t);
		int h;
		bit [31:0] c;
		if (list_match(blk_list, a) || private_net(a)) return 1'b0;
		h = cache_find(hot_v, hot_a, a);
		if (h >= 0) begin
			cache_touch(hot_v, hot_rank, h);
			return 1'b1;
		end
		h = cache_find(pre_v, pre_a, a);
		if (h >= 0) begin
			cache_touch(pre_v, pre_rank, h);
			c = pre_cnt[h];
			if (c != 32'hFFFF_FFFF) c++;
			pre_cnt[h] = c;
			if (c >= thr_cfg && (t - pre_first[h]) > age_cfg) begin
				void'(cache_place(hot_v, hot_a, hot_rank, a));
				promotions++;
			end
			return 1'b1;
		end
		if (list_match(alw_list, a)) begin
			h = cache_place(pre_v, pre_a, pre_rank, a);
			pre_first[h] = t;
			pre_cnt[h] = 32'd1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic verdict_t predict_verdict(bit [1:0] rq, bit ok, bit [31:0] s,
			bit [31:0] d, bit [63:0] t, bit [31:0] pa, bit [5:0] pl);
		verdict_t vd;
		vd = '0;
		case (rq)
			REQ_LOAD_BLOCK: vd.full = list_add(blk_list, pa, pl);
			REQ_LOAD_ALLOW: vd.full = list_add(alw_list, pa, pl);
			REQ_PACKET: begin
				if (ok && !(private_net(s) && private_net(d))) begin
					if (addr_passes(d, t)) begin
						vd.acc = 1'b1;
						vd.side = SIDE_DST;
					end else if (addr_passes(s, t)) begin
						vd.acc = 1'b1;
						vd.side = SIDE_SRC;
					end
				end
			end
			default: ;
		endcase
		if (vd.acc) vd.mark = mark_cfg;
		if (vd.full) drops++;
		return vd;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
	endtask

	// result checker
	always @(posedge clk) begin
		verdict_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				report("unexpected result", 64'h0, 64'h0);
			end else begin
				w = verdict_q.pop_front();
				if (accelerate !== w.acc) report("accelerate", accelerate, w.acc);
				if (mark_out !== w.mark) report("mark_out", mark_out, w.mark);
				if (matched_side !== w.side) report("matched_side", matched_side, w.side);
				if (load_status !== w.full) report("load_status", load_status, w.full);
			end
			results_seen++;
		end
	end

	// receiver stall pattern, one draw per result transfer
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = rush ? 0 : $urandom_range(0, 10);
			if (hold_long > 0) begin
				n = hold_long;
				hold_long = 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic send_item(bit [1:0] rq, bit ok, bit [31:0] s, bit [31:0] d,
			bit [63:0] t, bit [31:0] pa, bit [5:0] pl);
		int gap;
		gap = rush ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_type <= rq;
		ipv4_ok <= ok;
		src_addr <= s;
		dst_addr <= d;
		now_ns <= t;
		prefix_addr <= pa;
		prefix_len <= pl;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		verdict_q.push_back(predict_verdict(rq, ok, s, d, t, pa, pl));
		items_sent++;
	endtask

	task automatic send_packet(bit [31:0] s, bit [31:0] d);
		clock_ns += $urandom_range(1, 40);
		send_item(REQ_PACKET, 1'b1, s, d, clock_ns, $urandom, $urandom_range(0, 63));
	endtask

	task automatic send_load(bit [1:0] rq, bit [31:0] pa, bit [5:0] pl);
		send_item(rq, $urandom_range(0, 1), $urandom, $urandom, {$urandom, $urandom}, pa, pl);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_HOT_COUNT_THRESHOLD: thr_cfg = val[31:0];
			CFG_HOT_AGE_NS: age_cfg = val;
			CFG_MARK_WORD: mark_cfg = val[31:0];
			default: ;
		endcase
	endtask

	function automatic bit [31:0] any_public();
		bit [31:0] a;
		do a = $urandom; while (private_net(a));
		return a;
	endfunction

	function automatic bit [31:0] any_private();
		case ($urandom_range(0, 2))
			0: return {8'h0A, 24'($urandom)};
			1: return {12'hAC1, 20'($urandom)};
			default: return {16'hC0A8, 16'($urandom)};
		endcase
	endfunction

	// loads, masking, duplicates, each packet path, unused request, field extremes
	task automatic test_directed();
		send_load(REQ_LOAD_BLOCK, 32'hC633_6577, 6'd24);
		send_load(REQ_LOAD_BLOCK, 32'hC633_6400, 6'd24);
		send_load(REQ_LOAD_ALLOW, 32'h6440_0000, 6'd10);
		send_load(REQ_LOAD_ALLOW, 32'h647F_FFFF, 6'd10);
		send_load(REQ_LOAD_ALLOW, 32'hCB00_7107, 6'd40);
		send_load(REQ_LOAD_ALLOW, 32'hFFFF_FFFF, 6'd63);
		send_item(REQ_PACKET, 1'b0, pool[0], pool[1], 64'd5, 32'h0, 6'd0);
		send_packet(32'h0A01_0203, 32'hC0A8_0101);
		send_packet(pool[0], 32'hAC1F_0001);
		send_packet(pool[0], 32'hC633_6405);
		send_packet(32'h0808_0808, pool[1]);
		send_packet(32'h0808_0808, pool[1]);
		send_packet(pool[2], 32'h0808_0808);
		send_packet(32'hCB00_7107, 32'hCB00_7108);
		send_item(REQ_UNUSED, 1'b1, pool[3], pool[3], 64'd9, 32'hFFFF_FFFF, 6'd63);
		send_item(REQ_PACKET, 1'b1, 32'h0, 32'h0, 64'h0, 32'h0, 6'd0);
		send_item(REQ_PACKET, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, 6'd63);
		send_item(REQ_PACKET, 1'b1, 32'hFFFF_FFFF, pool[1], '1, '1, 6'd63);
	endtask

	// pre-cache counts up and moves an address into the hot cache
	task automatic test_promotion();
		write_reg(CFG_HOT_COUNT_THRESHOLD, 64'd2);
		write_reg(CFG_HOT_AGE_NS, 64'd0);
		repeat (4) send_packet(pool[4], pool[5]);
		repeat (3) send_packet(any_public(), pool[6]);
	endtask

	task automatic test_random(int n);
		int r;
		bit [31:0] pa;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			pa = ($urandom_range(0, 1) != 0) ? pool[$urandom_range(0, POOL_N - 1)] : $urandom;
			if (r < 50)
				send_packet(($urandom_range(0, 2) == 0) ? pool[$urandom_range(0, POOL_N - 1)]
						: any_public(), pool[$urandom_range(0, POOL_N - 1)]);
			else if (r < 62)
				send_packet(pool[$urandom_range(0, POOL_N - 1)],
						($urandom_range(0, 1) != 0) ? any_private() : any_public());
			else if (r < 72)
				send_load($urandom_range(0, 1) ? REQ_LOAD_BLOCK : REQ_LOAD_ALLOW, pa,
						$urandom_range(12, 63));
			else if (r < 86)
				send_item($urandom_range(0, 3), $urandom_range(0, 1), $urandom, $urandom,
						{$urandom, $urandom}, $urandom, $urandom_range(0, 63));
			else
				send_packet(any_private(), ($urandom_range(0, 1) != 0) ? any_private()
						: pool[$urandom_range(0, POOL_N - 1)]);
		end
	endtask

	// long output hold while the input keeps offering, then a full pause
	task automatic test_backpressure();
		hold_long = 20000;
		rush = 1'b1;
		send_load(REQ_LOAD_ALLOW, 32'h6440_0000, 6'd10);
		repeat (3) send_packet(any_public(), pool[$urandom_range(0, POOL_N - 1)]);
		send_load(REQ_LOAD_BLOCK, 32'hC633_6400, 6'd24);
		send_packet(pool[7], any_public());
		rush = 1'b0;
		drain();
		send_packet(pool[8], pool[9]);
	endtask

	// fill the block list, overflow it, then repeat a stored prefix
	task automatic test_list_full();
		int k;
		k = 0;
		while (!blk_list[LIST_N - 1].v) begin
			send_load(REQ_LOAD_BLOCK, {16'hC612, 16'(k)}, 6'd32);
			k++;
		end
		send_load(REQ_LOAD_BLOCK, 32'hC613_0001, 6'd32);
		send_load(REQ_LOAD_BLOCK, 32'hC612_0000, 6'd32);
		send_load(REQ_LOAD_ALLOW, $urandom, 6'd0);
		send_packet(32'hC612_0003, any_public());
		send_packet(any_public(), any_public());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_PACKET;
		ipv4_ok = 1'b0;
		src_addr = '0;
		dst_addr = '0;
		now_ns = '0;
		prefix_addr = '0;
		prefix_len = '0;
		thr_cfg = RST_HOT_COUNT_THRESHOLD;
		age_cfg = RST_HOT_AGE_NS;
		mark_cfg = RST_MARK_WORD;
		clock_ns = 64'd1000;
		foreach (pool[i]) pool[i] = {10'b0110_0100_01, 22'($urandom)};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_promotion();
		test_random(5);
		write_reg(CFG_HOT_COUNT_THRESHOLD, 64'd1);
		write_reg(CFG_MARK_WORD, 64'hFFFF_FFFF);
		rush = 1'b1;
		test_random(3);
		rush = 1'b0;
		test_random(3);
		write_reg(CFG_HOT_COUNT_THRESHOLD, 64'hFFFF_FFFF);
		write_reg(CFG_HOT_AGE_NS, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(CFG_MARK_WORD, 64'd0);
		test_random(5);
		write_reg(CFG_HOT_COUNT_THRESHOLD, 64'd3);
		write_reg(CFG_HOT_AGE_NS, 64'd60);
		write_reg(CFG_MARK_WORD, 64'h5A5A_A5A5);
		test_random(4);
		test_backpressure();
		test_list_full();

		drain();
		repeat (200) @(posedge clk);
		$display("%0d items sent, %0d results checked: loads, packet paths, %0d promotions,",
				items_sent, results_seen, promotions);
		$display("%0d dropped prefixes, four register settings, stall and hold-off phases",
				drops);
		if (errors == 0)
			$display("ip_fastpath_classifier_unit_tb OK");
		else
			$display("ip_fastpath_classifier_unit_tb NOT OK");
		$finish;
	end

endmodule
